/* hw/rtl/rld_pkg.sv */
// Shared types, constants and byte classification functions for the repeated line detector.
package rld_pkg;

   // Field widths fixed by the interface.
   localparam int CHAR_W      = 8;
   localparam int STREAK_W    = 8;
   localparam int CFG_W       = 8;
   localparam int CSR_INDEX_W = 2;

   // A stored entry is one word character plus a flag for a space in front of it.
   localparam int ENTRY_W = CHAR_W + 1;

   // Command codes.
   localparam logic CMD_TEXT  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_STREAK_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LINE_CHARS   = CSR_INDEX_W'(1);

   // Register reset values.
   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 8'd5;
   localparam logic [CFG_W-1:0] MIN_CHARS_RESET = 8'd6;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

   typedef struct packed {
      logic              command;
      logic [CHAR_W-1:0] text_byte;
   } rld_item_type;

   typedef struct packed {
      logic                trigger_pulse;
      logic                triggered;
      logic [STREAK_W-1:0] streak_count;
   } rld_result_type;

   // Map A-Z onto a-z, leave every other byte alone.
   function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] b);
      logic [CHAR_W-1:0] r;
      r = b;
      if (b >= 8'd65 && b <= 8'd90) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

   // Whitespace: tab through carriage return, space, next line and no-break space.
   function automatic logic is_space_byte(input logic [CHAR_W-1:0] b);
      return (b >= 8'd9 && b <= 8'd13) || b == 8'd32 || b == 8'd133 || b == 8'd160;
   endfunction

   // Word characters are a-z and 0-9 after lowering.
   function automatic logic is_word_byte(input logic [CHAR_W-1:0] b);
      return (b >= 8'd97 && b <= 8'd122) || (b >= 8'd48 && b <= 8'd57);
   endfunction

endpackage

/* hw/rtl/rld_line_store.sv */
// Two-bank line memory with one write port and one registered read port.
module rld_line_store #(
   parameter int DEPTH = 320
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(DEPTH)-1:0]           wr_addr,
   input  logic [rld_pkg::ENTRY_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]           rd_addr,
   output logic [rld_pkg::ENTRY_W-1:0]        rd_data
);
   import rld_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rld_core.sv */
// Line normalizer, line compare and streak logic; processes one transfer per cycle while advance is high.
module rld_core #(
   parameter int MAX_LINE_CHARS = 160
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  rld_pkg::rld_item_type                       item,
   input  logic [rld_pkg::CFG_W-1:0]                   streak_threshold,
   input  logic [rld_pkg::CFG_W-1:0]                   min_line_chars,
   input  logic [rld_pkg::ENTRY_W-1:0]                 rd_data,
   output logic [$clog2(2*MAX_LINE_CHARS)-1:0]         rd_addr,
   output logic                                        wr_en,
   output logic [$clog2(2*MAX_LINE_CHARS)-1:0]         wr_addr,
   output logic [rld_pkg::ENTRY_W-1:0]                 wr_data,
   output rld_pkg::rld_result_type                     result
);
   import rld_pkg::*;

   localparam int LEN_W = $clog2(MAX_LINE_CHARS + 1);
   localparam int IDX_W = $clog2(MAX_LINE_CHARS);
   localparam int ADDR_W = $clog2(2 * MAX_LINE_CHARS);
   localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam logic [LEN_W:0] MAX_EXT = (LEN_W + 1)'(MAX_LINE_CHARS);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE_CHARS);
   localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(MAX_LINE_CHARS);

   // Line under construction, previous counted line, and guard state.
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    ent_ff, ent_in;
   logic [LEN_W-1:0]    prev_len_ff, prev_len_in;
   logic [LEN_W-1:0]    prev_ent_ff, prev_ent_in;
   logic                bank_ff, bank_in;
   logic                pend_ff, pend_in;
   logic                nonblank_ff, nonblank_in;
   logic                mism_ff, mism_in;
   logic [STREAK_W-1:0] streak_ff, streak_in;
   logic                trig_ff, trig_in;

   logic [CHAR_W-1:0]   lower_byte;
   logic [LEN_W:0]      len_ext;
   logic                sep;
   logic                fire;
   logic                line_match;
   logic [ENTRY_W-1:0]  entry;
   logic [IDX_W-1:0]    wr_idx;
   logic [IDX_W-1:0]    rd_idx;

   assign lower_byte = to_lower(item.text_byte);
   assign len_ext    = {1'b0, len_ff};
   assign sep        = pend_ff && (len_ff != '0);
   assign line_match = !mism_ff && (len_ff == prev_len_ff) && (ent_ff == prev_ent_ff);

   // Next state for one transfer.
   always_comb begin
      len_in      = len_ff;
      ent_in      = ent_ff;
      prev_len_in = prev_len_ff;
      prev_ent_in = prev_ent_ff;
      bank_in     = bank_ff;
      pend_in     = pend_ff;
      nonblank_in = nonblank_ff;
      mism_in     = mism_ff;
      streak_in   = streak_ff;
      trig_in     = trig_ff;
      fire        = 1'b0;
      wr_en       = 1'b0;
      entry       = {sep, lower_byte};
      if (advance) begin
         if (item.command == CMD_CLEAR) begin
            len_in      = '0;
            ent_in      = '0;
            prev_len_in = '0;
            prev_ent_in = '0;
            bank_in     = 1'b0;
            pend_in     = 1'b0;
            nonblank_in = 1'b0;
            mism_in     = 1'b0;
            streak_in   = '0;
            trig_in     = 1'b0;
         end else if (!trig_ff) begin
            if (item.text_byte == CHAR_NEWLINE) begin
               // End of line: count it if it qualifies, then start a new line.
               if (nonblank_ff && CMP_W'(len_ff) >= CMP_W'(min_line_chars)) begin
                  if (line_match) begin
                     if (streak_ff != STREAK_MAX) begin
                        streak_in = streak_ff + STREAK_W'(1);
                     end
                  end else begin
                     streak_in   = STREAK_W'(1);
                     prev_len_in = len_ff;
                     prev_ent_in = ent_ff;
                     bank_in     = ~bank_ff;
                  end
                  if (streak_in >= streak_threshold) begin
                     fire    = 1'b1;
                     trig_in = 1'b1;
                  end
               end
               len_in      = '0;
               ent_in      = '0;
               pend_in     = 1'b0;
               nonblank_in = 1'b0;
               mism_in     = 1'b0;
            end else begin
               if (!is_space_byte(lower_byte)) begin
                  nonblank_in = 1'b1;
               end
               if (is_word_byte(lower_byte)) begin
                  pend_in = 1'b0;
                  if (sep ? (len_ext + (LEN_W + 1)'(2) <= MAX_EXT) : (len_ext < MAX_EXT)) begin
                     // Store the character with its separator flag and compare it.
                     wr_en  = 1'b1;
                     len_in = LEN_W'(len_ext + (sep ? (LEN_W + 1)'(2) : (LEN_W + 1)'(1)));
                     ent_in = ent_ff + LEN_W'(1);
                     if (ent_ff >= prev_ent_ff || rd_data != entry) begin
                        mism_in = 1'b1;
                     end
                  end else if (sep && len_ext < MAX_EXT) begin
                     // Only the separator fits: the cut line ends in a space.
                     len_in = MAX_LEN;
                  end
               end else begin
                  pend_in = 1'b1;
               end
            end
         end
      end
   end

   // Memory addressing: write the current bank, prefetch the other bank.
   assign wr_idx  = ent_ff[IDX_W-1:0];
   assign wr_addr = bank_ff ? (BANK_BASE + ADDR_W'(wr_idx)) : ADDR_W'(wr_idx);
   assign wr_data = entry;
   assign rd_idx  = (ent_in < MAX_LEN) ? ent_in[IDX_W-1:0] : '0;
   assign rd_addr = bank_in ? ADDR_W'(rd_idx) : (BANK_BASE + ADDR_W'(rd_idx));

   // Result of this transfer.
   assign result.trigger_pulse = fire;
   assign result.triggered     = trig_in;
   assign result.streak_count  = streak_in;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         ent_ff      <= '0;
         prev_len_ff <= '0;
         prev_ent_ff <= '0;
         bank_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         nonblank_ff <= 1'b0;
         mism_ff     <= 1'b0;
         streak_ff   <= '0;
         trig_ff     <= 1'b0;
      end else begin
         len_ff      <= len_in;
         ent_ff      <= ent_in;
         prev_len_ff <= prev_len_in;
         prev_ent_ff <= prev_ent_in;
         bank_ff     <= bank_in;
         pend_ff     <= pend_in;
         nonblank_ff <= nonblank_in;
         mism_ff     <= mism_in;
         streak_ff   <= streak_in;
         trig_ff     <= trig_in;
      end
   end

   // The stored entry count never runs ahead of the line length.
   a_ent_le_len: assert property (@(posedge clock) disable iff (reset)
      (ent_ff <= len_ff) && (prev_ent_ff <= prev_len_ff))
      else $error("entry count exceeds line length");

   // The line length never passes the cut.
   a_len_cut: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= MAX_LEN) && (prev_len_ff <= MAX_LEN))
      else $error("line length beyond the cut");

   // Once triggered, text transfers leave the streak and flag alone.
   a_triggered_hold: assert property (@(posedge clock) disable iff (reset)
      (trig_ff && advance && item.command == CMD_TEXT) |=>
         (trig_ff && $stable(streak_ff)))
      else $error("triggered state changed by text");

   // A trigger pulse only comes with a streak that reached the threshold.
   a_pulse_streak: assert property (@(posedge clock) disable iff (reset)
      fire |-> (trig_in && !trig_ff && streak_in >= streak_threshold))
      else $error("trigger pulse without a qualifying streak");

   // The memory is written only while the line has room.
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (ent_ff < MAX_LEN && len_ff < MAX_LEN))
      else $error("line store written past the cut");

endmodule

/* hw/rtl/repeated_line_detector.sv */
// Top level of the repeated line detector: handshake registers, configuration and core.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+-------------------------------
//   request | req_valid, req_stall           | in        | req_command, req_text_byte
//   result  | rsp_valid, rsp_stall           | out       | rsp_trigger_pulse,
//           |                                |           | rsp_triggered, rsp_streak_count
//   config  | csr_valid, csr_ready           | in        | csr_index, csr_data
//
// One byte is taken every cycle unless req_stall is high; it waits in the input register and
// its result goes to the result register. The line compare reads one previous-line entry per
// cycle from a single registered-read memory, prefetched from the next entry count.
// Reset clears all control state at once; the line memory needs no clearing pass.
// A stalled result holds the processing stage, and the request side stalls in turn.
module repeated_line_detector #(
   parameter int MAX_LINE_CHARS = 160
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [rld_pkg::CHAR_W-1:0]          req_text_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_trigger_pulse,
   output logic                                rsp_triggered,
   output logic [rld_pkg::STREAK_W-1:0]        rsp_streak_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rld_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rld_pkg::CFG_W-1:0]           csr_data
);
   import rld_pkg::*;

   localparam int DEPTH  = 2 * MAX_LINE_CHARS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                in_valid_ff, in_valid_in;
   rld_item_type        in_item_ff;
   logic                out_valid_ff, out_valid_in;
   rld_result_type      out_result_ff;
   logic [CFG_W-1:0]    threshold_ff;
   logic [CFG_W-1:0]    min_chars_ff;

   logic                advance;
   logic                req_take;
   rld_result_type      core_result;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;

   // Handshake: the stage advances when the result register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command   <= req_command;
         in_item_ff.text_byte <= req_text_byte;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_pulse = out_result_ff.trigger_pulse;
   assign rsp_triggered     = out_result_ff.triggered;
   assign rsp_streak_count  = out_result_ff.streak_count;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         min_chars_ff <= MIN_CHARS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_STREAK_THRESHOLD) begin
            threshold_ff <= csr_data;
         end
         if (csr_index == CSR_MIN_LINE_CHARS) begin
            min_chars_ff <= csr_data;
         end
      end
   end

   // Processing stage.
   rld_core #(
      .MAX_LINE_CHARS(MAX_LINE_CHARS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .item             (in_item_ff),
      .streak_threshold (threshold_ff),
      .min_line_chars   (min_chars_ff),
      .rd_data          (rd_data),
      .rd_addr          (rd_addr),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .result           (core_result)
   );

   // Line memory holding the current and the previous line.
   rld_line_store #(
      .DEPTH(DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the repeated line detector: stimulus, line predictor and checks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rld_pkg::*;

   localparam int LINE_MAX       = 160;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // Register index that the block does not implement.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = CSR_INDEX_W'(2);

   // Character codes used by the predictor and the stimulus.
   localparam logic [CHAR_W-1:0] CH_UP_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z     = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOW_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_NEL      = 8'h85;
   localparam logic [CHAR_W-1:0] CH_NBSP     = 8'hA0;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   // Whitespace bytes other than newline.
   localparam logic [CHAR_W-1:0] BLANK_SET [0:6] =
      '{CH_TAB, 8'h0B, 8'h0C, CH_CR, CH_SPACE, CH_NEL, CH_NBSP};

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_command = CMD_TEXT;
   logic [CHAR_W-1:0]      req_text_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_trigger_pulse;
   logic                   rsp_triggered;
   logic [STREAK_W-1:0]    rsp_streak_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data = '0;

   repeated_line_detector uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trigger_pulse (rsp_trigger_pulse),
      .rsp_triggered     (rsp_triggered),
      .rsp_streak_count  (rsp_streak_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Bytes waiting to be sent and line results waiting to arrive.
   rld_item_type   pending_bytes[$];
   rld_result_type predicted_results[$];

   int unsigned items_queued     = 0;
   int unsigned items_accepted   = 0;
   int unsigned results_seen     = 0;
   int unsigned mismatch_count   = 0;
   int unsigned pulses_predicted = 0;
   int unsigned quiet_cycles     = 0;
   int unsigned send_idle_pct    = 25;
   int unsigned recv_idle_pct    = 49;
   logic [STREAK_W-1:0] peak_streak = '0;

   string vocab [0:7] = '{"ab", "loop", "x9", "retry", "id42", "zz", "ok", "again"};

   // Predictor state: two line banks, the line being built and the streak.
   logic [CHAR_W-1:0]   line_store [0:1][0:LINE_MAX-1];
   int unsigned         cur_len;
   int unsigned         prev_len;
   bit                  cur_bank;
   bit                  sep_owed;
   bit                  saw_nonblank;
   bit                  diff_seen;
   bit                  guard_tripped;
   logic [STREAK_W-1:0] streak_now;
   logic [CFG_W-1:0]    cfg_threshold;
   logic [CFG_W-1:0]    cfg_min_chars;

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] b);
      if (b >= CH_UP_A && b <= CH_UP_Z) begin
         return b + CASE_OFFSET;
      end
      return b;
   endfunction

   function automatic bit blank_char(input logic [CHAR_W-1:0] b);
      return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE || b == CH_NEL || b == CH_NBSP;
   endfunction

   function automatic bit word_char(input logic [CHAR_W-1:0] b);
      return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_ZERO && b <= CH_NINE);
   endfunction

   function automatic void restart_line();
      cur_len      = 0;
      sep_owed     = 1'b0;
      saw_nonblank = 1'b0;
      diff_seen    = 1'b0;
   endfunction

   function automatic void clear_guard_state();
      restart_line();
      prev_len      = 0;
      cur_bank      = 1'b0;
      streak_now    = '0;
      guard_tripped = 1'b0;
   endfunction

   // Store one normalized character and compare it with the previous line.
   function automatic void append_char(input logic [CHAR_W-1:0] c);
      if (cur_len >= LINE_MAX) begin
         return;
      end
      line_store[cur_bank][cur_len] = c;
      if (cur_len >= prev_len || line_store[~cur_bank][cur_len] != c) begin
         diff_seen = 1'b1;
      end
      cur_len++;
   endfunction

   // Close the line on a newline; returns 1 when the streak trips the guard.
   function automatic bit close_line();
      bit fired;
      fired = 1'b0;
      if (saw_nonblank && cur_len >= cfg_min_chars) begin
         if (!diff_seen && cur_len == prev_len) begin
            if (streak_now != STREAK_MAX) begin
               streak_now++;
            end
         end else begin
            streak_now = 8'd1;
            prev_len   = cur_len;
            cur_bank   = ~cur_bank;
         end
         if (streak_now >= cfg_threshold) begin
            guard_tripped = 1'b1;
            fired         = 1'b1;
         end
      end
      restart_line();
      return fired;
   endfunction

   // Expected result for one accepted byte or clear command.
   function automatic rld_result_type predict_byte(input logic cmd, input logic [CHAR_W-1:0] raw);
      rld_result_type r;
      logic [CHAR_W-1:0] b;
      bit fired;
      fired = 1'b0;
      b     = fold_case(raw);
      if (cmd == CMD_CLEAR) begin
         clear_guard_state();
      end else if (!guard_tripped) begin
         if (raw == CHAR_NEWLINE) begin
            fired = close_line();
         end else begin
            if (!blank_char(b)) begin
               saw_nonblank = 1'b1;
            end
            if (word_char(b)) begin
               if (sep_owed && cur_len > 0) begin
                  append_char(CH_SPACE);
               end
               sep_owed = 1'b0;
               append_char(b);
            end else begin
               sep_owed = 1'b1;
            end
         end
      end
      r.trigger_pulse = fired;
      r.triggered     = guard_tripped;
      r.streak_count  = streak_now;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("MISMATCH at result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
   endtask

   // Stimulus helpers.
   task automatic queue_byte(input logic cmd, input logic [CHAR_W-1:0] b);
      rld_item_type it;
      it.command   = cmd;
      it.text_byte = b;
      pending_bytes = {pending_bytes, it};
      items_queued++;
   endtask

   task automatic queue_line(input string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(CMD_TEXT, s[i]);
      end
      queue_byte(CMD_TEXT, CHAR_NEWLINE);
   endtask

   function automatic logic [CHAR_W-1:0] pick_separator();
      logic [CHAR_W-1:0] b;
      if ($urandom_range(0, 99) < 50) begin
         return CH_SPACE;
      end
      do begin
         b = CHAR_W'($urandom_range(0, 255));
      end while (word_char(fold_case(b)) || b == CHAR_NEWLINE);
      return b;
   endfunction

   task automatic queue_separators(input int unsigned n);
      repeat (n) queue_byte(CMD_TEXT, pick_separator());
   endtask

   // Send a line with random case, separator runs and optional edge separators.
   task automatic queue_dressed(input string plain);
      logic [CHAR_W-1:0] c;
      if ($urandom_range(0, 99) < 30) begin
         queue_separators($urandom_range(1, 2));
      end
      for (int i = 0; i < plain.len(); i++) begin
         c = plain[i];
         if (c == CH_SPACE) begin
            queue_separators($urandom_range(1, 3));
         end else begin
            if (c >= CH_LOW_A && c <= CH_LOW_Z && $urandom_range(0, 1) == 1) begin
               c = c - CASE_OFFSET;
            end
            queue_byte(CMD_TEXT, c);
         end
      end
      if ($urandom_range(0, 99) < 30) begin
         queue_separators($urandom_range(1, 2));
      end
      queue_byte(CMD_TEXT, CHAR_NEWLINE);
   endtask

   function automatic string pick_line();
      string s;
      s = vocab[$urandom_range(0, 7)];
      repeat ($urandom_range(0, 2)) s = {s, " ", vocab[$urandom_range(0, 7)]};
      return s;
   endfunction

   // Mostly groups of repeated lines, with blank, punctuation, noise and clears mixed in.
   task automatic run_random(input int unsigned budget);
      int unsigned stop_at;
      int unsigned kind;
      int unsigned reps;
      string base;
      stop_at = items_queued + budget;
      while (items_queued < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            repeat ($urandom_range(1, 3)) queue_byte(CMD_TEXT, BLANK_SET[$urandom_range(0, 6)]);
            queue_byte(CMD_TEXT, CHAR_NEWLINE);
         end else if (kind < 14) begin
            queue_separators($urandom_range(1, 4));
            queue_byte(CMD_TEXT, CHAR_NEWLINE);
         end else if (kind < 20) begin
            repeat ($urandom_range(1, 6)) queue_byte(CMD_TEXT, CHAR_W'($urandom_range(0, 255)));
            queue_byte(CMD_TEXT, CHAR_NEWLINE);
         end else if (kind < 24) begin
            queue_byte(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)));
         end else begin
            base = pick_line();
            reps = $urandom_range(1, 6);
            for (int r = 0; r < reps; r++) begin
               if ($urandom_range(0, 99) < 15) begin
                  queue_dressed(pick_line());
               end else begin
                  queue_dressed(base);
               end
            end
            // A group long enough to trip the guard is usually followed by a clear.
            if ($urandom_range(0, 99) < ((reps >= cfg_threshold) ? 85 : 25)) begin
               queue_byte(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_STREAK_THRESHOLD) begin
         cfg_threshold = val;
      end else if (idx == CSR_MIN_LINE_CHARS) begin
         cfg_min_chars = val;
      end
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued byte has produced its result, then let the pipeline settle.
   task automatic wait_idle();
      while (results_seen < items_queued) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Driver: predicts each accepted transfer and presents the next pending byte.
   always @(posedge clock) begin : driver
      rld_item_type   nxt;
      rld_result_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted = predict_byte(req_command, req_text_byte);
            predicted_results = {predicted_results, predicted};
            items_accepted++;
            if (predicted.trigger_pulse) begin
               pulses_predicted++;
            end
            if (predicted.streak_count > peak_streak) begin
               peak_streak = predicted.streak_count;
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_command   <= nxt.command;
               req_text_byte <= nxt.text_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random backpressure and field-by-field compare of each result transfer.
   always @(posedge clock) begin : monitor
      rld_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
               report_mismatch("unexpected result, pending count", 1, 0);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_trigger_pulse !== want.trigger_pulse) begin
                  report_mismatch("trigger_pulse", rsp_trigger_pulse, want.trigger_pulse);
               end
               if (rsp_triggered !== want.triggered) begin
                  report_mismatch("triggered", rsp_triggered, want.triggered);
               end
               if (rsp_streak_count !== want.streak_count) begin
                  report_mismatch("streak_count", rsp_streak_count, want.streak_count);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no transfer happens on any channel for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, items_queued - results_seen);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence: directed checks, three random phases, then long truncated lines.
   initial begin : sequencer
      string long_a;
      string long_b;
      clear_guard_state();
      cfg_threshold = THRESHOLD_RESET;
      cfg_min_chars = MIN_CHARS_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: clear, a whitespace-only line, and a line too short to count.
      queue_byte(CMD_CLEAR, 8'hFF);
      queue_byte(CMD_TEXT, CH_TAB);
      queue_byte(CMD_TEXT, CH_CR);
      queue_byte(CMD_TEXT, CH_NEL);
      queue_byte(CMD_TEXT, CH_NBSP);
      queue_byte(CMD_TEXT, CH_SPACE);
      queue_byte(CMD_TEXT, CHAR_NEWLINE);
      queue_byte(CMD_TEXT, 8'h00);
      queue_line("Az09");
      queue_byte(CMD_TEXT, 8'hFF);
      queue_byte(CMD_TEXT, CHAR_NEWLINE);
      wait_idle();

      // Punctuation-only lines match the empty previous line, trip the guard, then get ignored.
      write_reg(CSR_STREAK_THRESHOLD, 8'd2);
      write_reg(CSR_MIN_LINE_CHARS, 8'd0);
      queue_line("!!");
      queue_line("#");
      queue_byte(CMD_TEXT, CH_UP_A);
      queue_byte(CMD_CLEAR, 8'h00);
      wait_idle();

      // A zero threshold trips on the first counted line.
      write_reg(CSR_STREAK_THRESHOLD, 8'd0);
      queue_line("Zz");
      queue_byte(CMD_CLEAR, 8'h5A);
      wait_idle();

      write_reg(CSR_STREAK_THRESHOLD, 8'd2);
      write_reg(CSR_MIN_LINE_CHARS, 8'd1);
      run_random(90);
      wait_idle();

      send_idle_pct = 49;
      recv_idle_pct = 25;
      write_reg(CSR_STREAK_THRESHOLD, 8'd3);
      write_reg(CSR_MIN_LINE_CHARS, 8'd4);
      write_reg(CSR_SPARE, 8'hA5);
      run_random(90);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_STREAK_THRESHOLD, THRESHOLD_RESET);
      write_reg(CSR_MIN_LINE_CHARS, MIN_CHARS_RESET);
      run_random(90);
      wait_idle();

      // Lines past the cut: both end in a written space at the last position and
      // differ only after it, so the second one extends the streak.
      write_reg(CSR_STREAK_THRESHOLD, 8'd255);
      write_reg(CSR_MIN_LINE_CHARS, 8'd160);
      long_a = "k00";
      long_b = "k00";
      for (int i = 1; i < 42; i++) begin
         long_a = {long_a, " ", $sformatf("k%02d", i)};
         long_b = {long_b, " ", (i < 40) ? $sformatf("k%02d", i) : $sformatf("q%02d", i)};
      end
      queue_byte(CMD_CLEAR, 8'h00);
      queue_line(long_a);
      queue_dressed(long_b);
      queue_line("k00 k01");
      wait_idle();

      if (predicted_results.size() != 0) begin
         report_mismatch("results never delivered", 0, predicted_results.size());
      end
      $display("Run covered %0d bytes and clears over seven register settings;", items_accepted);
      $display("%0d results checked, %0d guard trips, highest streak %0d.",
               results_seen, pulses_predicted, peak_streak);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
